[rtl/core/tls_client_hello_key_share_parser_assert.svh]
// Assertion macros shared by the ClientHello key-share parser RTL.
// Each macro expects clk_i and rst_ni in scope at the point of use.
`ifndef TLS_CLIENT_HELLO_KEY_SHARE_PARSER_ASSERT_SVH
`define TLS_CLIENT_HELLO_KEY_SHARE_PARSER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLSCH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TLSCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/tlsch_pkg.sv]
// Shared types and constants for the ClientHello key-share parser.
// No dependencies; imported by every module of the block.
package tlsch_pkg;

  localparam int unsigned MaxSessionId      = 32;
  localparam int unsigned RecordHeaderBytes = 5;
  localparam int unsigned HelloFixedBytes   = 38;
  localparam logic [15:0] HeadBytes         = 16'(RecordHeaderBytes + HelloFixedBytes);
  localparam logic [15:0] KeyShareType      = 16'h0033;
  localparam logic [7:0]  Tls13SuiteHi      = 8'h13;

  typedef enum logic [1:0] {
    KIND_KEY     = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE         = 2'd0,
    ERR_NO_KEY_SHARE = 2'd1,
    ERR_SID_TOO_LONG = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_record;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  key_byte;
    logic [15:0] key_index;
    logic [7:0]  cipher_code;
    logic [15:0] group_id;
    logic [15:0] key_length;
    logic [5:0]  session_id_length;
    err_e        error_code;
  } out_item_t;

endpackage

[rtl/core/tlsch_in_stage.sv]
// Input register of the ClientHello key-share parser.
// Depends on tlsch_pkg for the input item type.
module tlsch_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  tlsch_pkg::in_item_t in_data_i,
  output logic                in_stall_o,
  input  logic                pop_ready_i,
  output logic                item_valid_o,
  output tlsch_pkg::in_item_t item_o
);
  import tlsch_pkg::*;

  logic     valid_q, valid_d;
  in_item_t data_q;
  logic     take;

  assign in_stall_o = valid_q && !pop_ready_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (pop_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

[rtl/core/tlsch_parse_core.sv]
// Byte-step parse state machine for the ClientHello key-share parser.
// Depends on tlsch_pkg; assertions use the shared assertion macro header.
`include "tls_client_hello_key_share_parser_assert.svh"

module tlsch_parse_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  tlsch_pkg::in_item_t  item_i,
  output logic                 emit_o,
  output tlsch_pkg::out_item_t res_o
);
  import tlsch_pkg::*;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_HEAD   = 5'd1;
  localparam logic [4:0] PH_SIDLEN = 5'd2;
  localparam logic [4:0] PH_SID    = 5'd3;
  localparam logic [4:0] PH_CSLEN  = 5'd4;
  localparam logic [4:0] PH_CS     = 5'd5;
  localparam logic [4:0] PH_CMPLEN = 5'd6;
  localparam logic [4:0] PH_CMP    = 5'd7;
  localparam logic [4:0] PH_EXTLEN = 5'd8;
  localparam logic [4:0] PH_ETYPE  = 5'd9;
  localparam logic [4:0] PH_ELEN   = 5'd10;
  localparam logic [4:0] PH_EBODY  = 5'd11;
  localparam logic [4:0] PH_KSSKIP = 5'd12;
  localparam logic [4:0] PH_GROUP  = 5'd13;
  localparam logic [4:0] PH_KLEN   = 5'd14;
  localparam logic [4:0] PH_KEY    = 5'd15;
  localparam logic [4:0] PH_DONE   = 5'd16;

  logic [4:0]  phase_q, phase_d, ph;
  logic [15:0] cnt_q, cnt_d, cnt;
  logic [23:0] acc_q, acc_d, acc;
  logic [15:0] ext_q, ext_d, ext;
  logic        cf_q, cf_d, cf;
  logic [7:0]  cc_q, cc_d, cc;
  logic [15:0] grp_q, grp_d, grp;
  logic [15:0] kl_q, kl_d, kl;
  logic [5:0]  sl_q, sl_d, sl;

  logic [7:0]  b;
  logic [23:0] shifted;
  logic [15:0] cnt_m1;
  logic [15:0] ext_m1;
  logic [15:0] len;

  assign b       = item_i.data_byte;
  assign cnt_m1  = cnt - 16'd1;
  assign ext_m1  = ext - 16'd1;
  assign shifted = {acc[15:0], b};
  assign len     = shifted[15:0];

  always_comb begin
    ph  = phase_q;
    cnt = cnt_q;
    acc = acc_q;
    ext = ext_q;
    cf  = cf_q;
    cc  = cc_q;
    grp = grp_q;
    kl  = kl_q;
    sl  = sl_q;
    // A start flag restarts the parse from a clean state.
    if (item_i.start_of_record) begin
      ph  = PH_HEAD;
      cnt = HeadBytes;
      acc = '0;
      ext = '0;
      cf  = 1'b0;
      cc  = '0;
      grp = '0;
      kl  = '0;
      sl  = '0;
    end
  end

  always_comb begin
    phase_d = ph;
    cnt_d   = cnt;
    acc_d   = acc;
    ext_d   = ext;
    cf_d    = cf;
    cc_d    = cc;
    grp_d   = grp;
    kl_d    = kl;
    sl_d    = sl;
    emit_o  = 1'b0;
    res_o   = '0;

    case (ph)
      PH_HEAD, PH_SID, PH_CMP, PH_KSSKIP: begin
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          acc_d = '0;
          case (ph)
            PH_HEAD: begin
              phase_d = PH_SIDLEN;
              cnt_d   = 16'd1;
            end
            PH_SID: begin
              phase_d = PH_CSLEN;
              cnt_d   = 16'd2;
            end
            PH_CMP: begin
              phase_d = PH_EXTLEN;
              cnt_d   = 16'd2;
            end
            default: begin
              phase_d = PH_GROUP;
              cnt_d   = 16'd2;
            end
          endcase
        end
      end
      PH_SIDLEN: begin
        if (32'(b) > MaxSessionId) begin
          emit_o           = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_SID_TOO_LONG;
          phase_d          = PH_DONE;
        end else begin
          sl_d  = b[5:0];
          acc_d = '0;
          if (b == 8'd0) begin
            phase_d = PH_CSLEN;
            cnt_d   = 16'd2;
          end else begin
            phase_d = PH_SID;
            cnt_d   = {8'd0, b};
          end
        end
      end
      PH_CSLEN: begin
        acc_d = shifted;
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          if (len == 16'd0) begin
            phase_d = PH_CMPLEN;
            cnt_d   = 16'd1;
            acc_d   = '0;
          end else begin
            phase_d = PH_CS;
            cnt_d   = len;
            acc_d   = {8'd0, len};
          end
        end
      end
      PH_CS: begin
        // Low half of acc holds the list length; top byte holds the first byte of a pair.
        if ((acc[0] ^ cnt[0]) == 1'b0) begin
          acc_d = {b, acc[15:0]};
        end else if (!cf && (acc[23:16] == Tls13SuiteHi)) begin
          cf_d = 1'b1;
          cc_d = b;
        end
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          phase_d = PH_CMPLEN;
          cnt_d   = 16'd1;
          acc_d   = '0;
        end
      end
      PH_CMPLEN: begin
        acc_d = '0;
        if (b == 8'd0) begin
          phase_d = PH_EXTLEN;
          cnt_d   = 16'd2;
        end else begin
          phase_d = PH_CMP;
          cnt_d   = {8'd0, b};
        end
      end
      PH_EXTLEN: begin
        acc_d = shifted;
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          ext_d = len;
          if (len == 16'd0) begin
            emit_o           = 1'b1;
            res_o.kind       = KIND_ERROR;
            res_o.error_code = ERR_NO_KEY_SHARE;
            phase_d          = PH_DONE;
          end else begin
            phase_d = PH_ETYPE;
            cnt_d   = 16'd2;
            acc_d   = '0;
          end
        end
      end
      PH_ETYPE, PH_ELEN, PH_EBODY: begin
        if (ext == 16'd0) begin
          emit_o           = 1'b1;
          res_o.kind       = KIND_ERROR;
          res_o.error_code = ERR_NO_KEY_SHARE;
          phase_d          = PH_DONE;
        end else begin
          ext_d = ext_m1;
          cnt_d = cnt_m1;
          if (ph != PH_EBODY) begin
            acc_d = shifted;
          end
          if (cnt_m1 == 16'd0) begin
            acc_d = '0;
            if (ph == PH_ETYPE) begin
              cnt_d = (len == KeyShareType) ? 16'd4 : 16'd2;
              phase_d = (len == KeyShareType) ? PH_KSSKIP : PH_ELEN;
            end else if ((ph == PH_ELEN) && (len != 16'd0)) begin
              phase_d = PH_EBODY;
              cnt_d   = len;
            end else if (ext_m1 == 16'd0) begin
              // Extension boundary with the list used up.
              emit_o           = 1'b1;
              res_o.kind       = KIND_ERROR;
              res_o.error_code = ERR_NO_KEY_SHARE;
              phase_d          = PH_DONE;
            end else begin
              phase_d = PH_ETYPE;
              cnt_d   = 16'd2;
            end
          end
        end
      end
      PH_GROUP: begin
        acc_d = shifted;
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          grp_d   = len;
          phase_d = PH_KLEN;
          cnt_d   = 16'd2;
          acc_d   = '0;
        end
      end
      PH_KLEN: begin
        acc_d = shifted;
        cnt_d = cnt_m1;
        if (cnt_m1 == 16'd0) begin
          kl_d  = len;
          acc_d = '0;
          if (len == 16'd0) begin
            emit_o                  = 1'b1;
            res_o.kind              = KIND_SUMMARY;
            res_o.cipher_code       = cc;
            res_o.group_id          = grp;
            res_o.key_length        = len;
            res_o.session_id_length = sl;
            phase_d                 = PH_DONE;
          end else begin
            phase_d = PH_KEY;
            cnt_d   = 16'd0;
          end
        end
      end
      PH_KEY: begin
        emit_o          = 1'b1;
        res_o.key_byte  = b;
        res_o.key_index = cnt;
        if (({1'b0, cnt} + 17'd1) == {1'b0, kl}) begin
          // Last key byte rides on the summary.
          res_o.kind              = KIND_SUMMARY;
          res_o.cipher_code       = cc;
          res_o.group_id          = grp;
          res_o.key_length        = kl;
          res_o.session_id_length = sl;
          phase_d                 = PH_DONE;
        end else begin
          res_o.kind = KIND_KEY;
          cnt_d      = cnt + 16'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      acc_q   <= '0;
      ext_q   <= '0;
      cf_q    <= 1'b0;
      cc_q    <= '0;
      grp_q   <= '0;
      kl_q    <= '0;
      sl_q    <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      ext_q   <= ext_d;
      cf_q    <= cf_d;
      cc_q    <= cc_d;
      grp_q   <= grp_d;
      kl_q    <= kl_d;
      sl_q    <= sl_d;
    end
  end

  `TLSCH_ASSERT_NEXT(a_final_goes_done, step_i && emit_o && (res_o.kind != KIND_KEY), phase_q == PH_DONE, "summary or error did not end the parse")
  `TLSCH_ASSERT_SAME(a_emit_only_when_active, emit_o && !item_i.start_of_record, phase_q != PH_IDLE && phase_q != PH_DONE, "result from an idle parser")
  `TLSCH_ASSERT_SAME(a_key_in_range, step_i && emit_o && (res_o.kind == KIND_KEY), res_o.key_index < kl, "key index beyond key length")

endmodule

[rtl/core/tlsch_out_stage.sv]
// Result register of the ClientHello key-share parser.
// Depends on tlsch_pkg for the result item type.
module tlsch_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tlsch_pkg::out_item_t res_i,
  output logic                 ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tlsch_pkg::out_item_t out_data_o
);
  import tlsch_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  // Free when empty or when the held result transfers this cycle.
  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && push_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[rtl/core/tls_client_hello_key_share_parser.sv]
// ClientHello key-share parser: takes a TLS record one byte per transfer (start_of_record on
// the first byte), skips the record header and fixed hello fields, picks the first TLS 1.3
// cipher suite, walks the extensions to key_share and emits every public-key byte with its
// index; the last key byte travels on the summary item, and a missing key share or an
// oversized session id gives an error item. One byte is accepted per cycle while the output
// is not stalled; an accepted byte goes from the input register through the parse step, whose
// result, if any, is written into the result register, and the parse step sets that rate.
// Depends on tlsch_pkg, tlsch_in_stage, tlsch_parse_core and tlsch_out_stage.
`include "tls_client_hello_key_share_parser_assert.svh"

module tls_client_hello_key_share_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  tlsch_pkg::in_item_t  in_data_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output tlsch_pkg::out_item_t out_data_o
);
  import tlsch_pkg::*;

  logic      item_valid;
  in_item_t  item;
  logic      out_ready;
  logic      step;
  logic      emit;
  out_item_t res;

  assign step = item_valid && out_ready;

  tlsch_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .pop_ready_i  (out_ready),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tlsch_parse_core u_parse_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .emit_o (emit),
    .res_o  (res)
  );

  tlsch_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step && emit),
    .res_i       (res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `TLSCH_ASSERT_SAME(a_stall_needs_backup, in_stall_o, out_valid_o && out_stall_i, "input stalled while output free")
  `TLSCH_ASSERT_SAME(a_error_has_code, out_valid_o && (out_data_o.kind == KIND_ERROR), out_data_o.error_code != ERR_NONE, "error item without code")
  `TLSCH_ASSERT_SAME(a_code_only_on_error, out_valid_o && (out_data_o.kind != KIND_ERROR), out_data_o.error_code == ERR_NONE, "code on a non-error item")

endmodule
